// ===== rtl/mst_pkg.sv =====
// shared types, codes and defaults for the multi-slot countdown timer
`default_nettype none
package mst_pkg;

  localparam int SLOTS_DEF = 8;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ATTACH = 2'd1;
  localparam logic [1:0] OP_DETACH = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  slot;
    logic [30:0] period;
    logic        cyclic;
  } req_t;

  typedef struct packed {
    logic [2:0] attached_slot;
    logic       no_free_slot;
    logic [7:0] fired_mask;
  } rsp_t;

  // one table entry held in the slot memory
  typedef struct packed {
    logic [30:0] period;
    logic [30:0] count;
  } slot_ent_t;

  // outcome of one slot pass through the shared decrementer
  typedef struct packed {
    logic [30:0] count;
    logic        fire;
    logic        free;
  } dec_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_ATTACH,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/mst_mem.sv =====
// slot table memory: period and counter, one write and one registered read port
`default_nettype none
module mst_mem #(
  parameter int SLOTS = mst_pkg::SLOTS_DEF,
  parameter int IW    = 3
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [IW-1:0]     waddr,
  input  wire mst_pkg::slot_ent_t wdata,
  input  wire logic [IW-1:0]     raddr,
  output mst_pkg::slot_ent_t     rdata
);

  mst_pkg::slot_ent_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/mst_dec.sv =====
// shared decrement, zero compare and reload unit for one slot
`default_nettype none
module mst_dec (
  input  wire logic [30:0]    count,
  input  wire logic [30:0]    period,
  input  wire logic           cyclic,
  output mst_pkg::dec_res_t   res
);

  logic [30:0] dec;

  always_comb begin
    dec       = count - 31'd1;
    res.count = count;
    res.fire  = 1'b0;
    res.free  = 1'b0;
    if (count != 31'd0) begin
      res.count = dec;
      if (dec == 31'd0) begin
        res.fire = 1'b1;
        if (cyclic) begin
          res.count = period;
        end else begin
          res.free = 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/multi_slot_countdown_timer_unit.sv =====
// top level: sequencer walking the slot table with one shared decrementer
// tick: one slot read per cycle plus write-back;
// when the last slot is active, done waits until its write-back drains
// attach: the free-slot scan tests one slot per cycle
// detach and unused opcodes go straight to done; one transaction in flight, a waiting result stalls done
// rst (synchronous) frees every slot via the active bits; the table memory is not cleared
`default_nettype none
module multi_slot_countdown_timer_unit #(
  parameter int SLOTS = mst_pkg::SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire mst_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output mst_pkg::rsp_t      rsp
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] LAST = CW'(SLOTS);

  mst_pkg::state_t state, state_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [SLOTS-1:0] active, active_next;
  logic [SLOTS-1:0] cyclic, cyclic_next;
  logic             rd_vld, rd_vld_next;
  logic [IW-1:0]    rd_idx;
  logic [30:0]      att_period;
  logic             att_cyclic;
  logic             att_load;
  logic [2:0]       res_attached, res_attached_next;
  logic             res_full, res_full_next;
  logic [7:0]       res_fired, res_fired_next;
  logic             rsp_load;

  logic               issue;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      sel;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  mst_pkg::slot_ent_t mem_wdata;
  mst_pkg::slot_ent_t mem_rdata;
  mst_pkg::dec_res_t  dres;

  assign idx = cnt[IW-1:0];
  assign sel = IW'(req.slot);

  mst_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx),
    .rdata (mem_rdata)
  );

  mst_dec u_dec (
    .count  (mem_rdata.count),
    .period (mem_rdata.period),
    .cyclic (cyclic[rd_idx]),
    .res    (dres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mst_pkg::ST_IDLE;
      cnt       <= '0;
      active    <= '0;
      cyclic    <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      active <= active_next;
      cyclic <= cyclic_next;
      rd_vld <= rd_vld_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx       <= idx;
    res_attached <= res_attached_next;
    res_full     <= res_full_next;
    res_fired    <= res_fired_next;
    if (att_load) begin
      att_period <= req.period;
      att_cyclic <= req.cyclic;
    end
    if (rsp_load) begin
      rsp.attached_slot <= res_attached;
      rsp.no_free_slot  <= res_full;
      rsp.fired_mask    <= res_fired;
    end
  end

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    active_next       = active;
    cyclic_next       = cyclic;
    res_attached_next = res_attached;
    res_full_next     = res_full;
    res_fired_next    = res_fired;
    req_ready         = (state == mst_pkg::ST_IDLE);
    att_load          = 1'b0;
    rsp_load          = 1'b0;
    issue             = (state == mst_pkg::ST_TICK) && (cnt != LAST);
    rd_vld_next       = issue && active[idx];
    mem_we            = 1'b0;
    mem_waddr         = rd_idx;
    mem_wdata         = {mem_rdata.period, dres.count};

    // second stage of the tick walk: write back the slot read last cycle
    if (rd_vld) begin
      mem_we = 1'b1;
      if (dres.free) begin
        active_next[rd_idx] = 1'b0;
      end
      if (dres.fire && (32'(rd_idx) < 32'd8)) begin
        res_fired_next[3'(rd_idx)] = 1'b1;
      end
    end

    case (state)
      mst_pkg::ST_IDLE: begin
        if (req_valid) begin
          cnt_next          = '0;
          res_attached_next = '0;
          res_full_next     = 1'b0;
          res_fired_next    = '0;
          case (req.opcode)
            mst_pkg::OP_TICK: begin
              state_next = mst_pkg::ST_TICK;
            end
            mst_pkg::OP_ATTACH: begin
              att_load   = 1'b1;
              state_next = mst_pkg::ST_ATTACH;
            end
            mst_pkg::OP_DETACH: begin
              if (32'(req.slot) < 32'(SLOTS)) begin
                active_next[sel] = 1'b0;
                cyclic_next[sel] = 1'b0;
              end
              state_next = mst_pkg::ST_DONE;
            end
            default: begin
              state_next = mst_pkg::ST_DONE;
            end
          endcase
        end
      end
      mst_pkg::ST_TICK: begin
        if (issue) begin
          cnt_next = cnt + CW'(1);
        end else if (!rd_vld) begin
          state_next = mst_pkg::ST_DONE;
        end
      end
      mst_pkg::ST_ATTACH: begin
        if (cnt == LAST) begin
          res_full_next = 1'b1;
          state_next    = mst_pkg::ST_DONE;
        end else if (!active[idx]) begin
          mem_we            = 1'b1;
          mem_waddr         = idx;
          mem_wdata         = {att_period, att_period};
          active_next[idx]  = 1'b1;
          cyclic_next[idx]  = att_cyclic;
          res_attached_next = 3'(idx);
          state_next        = mst_pkg::ST_DONE;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      mst_pkg::ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = mst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mst_pkg::ST_IDLE;
      end
    endcase
  end

  // an accepted transaction always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state != mst_pkg::ST_IDLE)
    else $error("accepted transaction did not start");

  // write-back stage only runs behind the tick walk
  a_rd_in_tick: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> state == mst_pkg::ST_TICK)
    else $error("write-back outside tick walk");

  // table writes only from the tick walk or an attach
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == mst_pkg::ST_TICK || state == mst_pkg::ST_ATTACH)
    else $error("table write in wrong state");

  // a full table never reports a slot or a fired mask
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.no_free_slot |-> rsp.attached_slot == 3'd0 && rsp.fired_mask == 8'd0)
    else $error("full flag with other result fields set");

  // result register loads only when free or being drained
  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> !rsp_valid || rsp_ready)
    else $error("result overwritten before transfer");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench for the multi-slot countdown timer unit
`timescale 1ns / 1ps
module tb_top;

  localparam int NSLOT = mst_pkg::SLOTS_DEF;
  localparam int RAND_ITEMS = 1900;
  localparam int TAIL_CYCLES = 4 * (NSLOT + 3);
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  mst_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  mst_pkg::rsp_t rsp;

  multi_slot_countdown_timer_unit #(.SLOTS(NSLOT)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the timer table
  logic        tt_active [NSLOT] = '{default: 1'b0};
  logic        tt_cyclic [NSLOT] = '{default: 1'b0};
  logic [30:0] tt_period [NSLOT] = '{default: '0};
  logic [30:0] tt_count  [NSLOT] = '{default: '0};

  mst_pkg::req_t pending_reqs [$];
  mst_pkg::rsp_t expected_rsps [$];
  mst_pkg::rsp_t want;

  int n_accepted = 0;
  int n_mismatch = 0;
  int n_cycles = 0;
  int n_tick = 0, n_attach = 0, n_full = 0, n_detach = 0, n_unused = 0, n_fire_ticks = 0;
  logic quiet;

  // idling switched off for a stretch in the middle of the run
  assign quiet = (n_accepted >= 800) && (n_accepted < 1200);

  function automatic mst_pkg::rsp_t timer_table_apply(mst_pkg::req_t r);
    mst_pkg::rsp_t o;
    bit   hit;
    o = '0;
    hit = 1'b0;
    case (r.opcode)
      mst_pkg::OP_TICK: begin
        n_tick++;
        for (int i = 0; i < NSLOT; i++) begin
          if (tt_active[i] && tt_count[i] != 0) begin
            tt_count[i] = tt_count[i] - 31'd1;
            if (tt_count[i] == 0) begin
              if (i < 8) o.fired_mask[i] = 1'b1;
              if (tt_cyclic[i]) tt_count[i] = tt_period[i];
              else tt_active[i] = 1'b0;
            end
          end
        end
        if (o.fired_mask != 0) n_fire_ticks++;
      end
      mst_pkg::OP_ATTACH: begin
        n_attach++;
        for (int i = 0; i < NSLOT; i++) begin
          if (!hit && !tt_active[i]) begin
            hit = 1'b1;
            tt_active[i] = 1'b1;
            tt_cyclic[i] = r.cyclic;
            tt_period[i] = r.period;
            tt_count[i] = r.period;
            o.attached_slot = 3'(i);
          end
        end
        if (!hit) begin
          o.no_free_slot = 1'b1;
          n_full++;
        end
      end
      mst_pkg::OP_DETACH: begin
        n_detach++;
        if (int'(r.slot) < NSLOT) begin
          tt_active[r.slot] = 1'b0;
          tt_cyclic[r.slot] = 1'b0;
          tt_period[r.slot] = '0;
          tt_count[r.slot] = '0;
        end
      end
      default: n_unused++;
    endcase
    return o;
  endfunction

  // driver: one transaction in flight on the request side
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(timer_table_apply(req));
        n_accepted++;
      end
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= 6)) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= quiet || ($urandom_range(0, 99) >= 6);
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected result: attached_slot=%0d no_free_slot=%0d fired_mask=%02h",
                     rsp.attached_slot, rsp.no_free_slot, rsp.fired_mask);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.attached_slot !== want.attached_slot || rsp.no_free_slot !== want.no_free_slot
              || rsp.fired_mask !== want.fired_mask) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display({"mismatch at cycle %0d: attached_slot %0d/%0d no_free_slot %0d/%0d",
                        " fired_mask %02h/%02h (exp/act)"},
                       n_cycles, want.attached_slot, rsp.attached_slot, want.no_free_slot,
                       rsp.no_free_slot, want.fired_mask, rsp.fired_mask);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               expected_rsps.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_req(logic [1:0] op, logic [2:0] sl, logic [30:0] per, logic cyc);
    mst_pkg::req_t t;
    t.opcode = op;
    t.slot = sl;
    t.period = per;
    t.cyclic = cyc;
    pending_reqs.push_back(t);
  endtask

  function automatic logic [30:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 31'($urandom_range(1, 8));
    if (r < 75) return '0;
    if (r < 88) return 31'($urandom_range(9, 64));
    if (r < 92) return 31'h7fff_ffff;
    return 31'($urandom);
  endfunction

  initial begin
    int mode;
    int len;
    int r;
    int made;
    logic [1:0] op;

    // zero period, cyclic period one, one-shot period two, largest period
    queue_req(mst_pkg::OP_ATTACH, 3'd7, 31'd0, 1'b0);
    queue_req(mst_pkg::OP_ATTACH, 3'd0, 31'd1, 1'b1);
    queue_req(mst_pkg::OP_ATTACH, 3'd5, 31'd2, 1'b0);
    queue_req(mst_pkg::OP_ATTACH, 3'd2, 31'h7fff_ffff, 1'b1);
    queue_req(mst_pkg::OP_TICK, 3'd7, 31'h7fff_ffff, 1'b1);
    queue_req(mst_pkg::OP_TICK, 3'd0, 31'd0, 1'b0);
    // freed one-shot slot is taken again, then the table fills up
    for (int i = 0; i < 5; i++)
      queue_req(mst_pkg::OP_ATTACH, 3'(i), 31'(3 + i), 1'(i & 1));
    queue_req(mst_pkg::OP_ATTACH, 3'd3, 31'd5, 1'b1);
    queue_req(OP_UNUSED, 3'd7, 31'h7fff_ffff, 1'b1);
    queue_req(mst_pkg::OP_DETACH, 3'd0, 31'd0, 1'b0);
    queue_req(mst_pkg::OP_DETACH, 3'd0, 31'h5555_5555, 1'b1);
    queue_req(mst_pkg::OP_TICK, 3'd4, 31'd9, 1'b1);
    for (int i = 0; i < NSLOT; i++)
      queue_req(mst_pkg::OP_DETACH, 3'(i), 31'($urandom), 1'($urandom));

    // random episodes: filling, counting down or draining the table
    made = 0;
    while (made < RAND_ITEMS) begin
      mode = $urandom_range(0, 2);
      len = $urandom_range(20, 60);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0: op = (r < 50) ? mst_pkg::OP_ATTACH : (r < 80) ? mst_pkg::OP_TICK
                  : (r < 96) ? mst_pkg::OP_DETACH : OP_UNUSED;
          1: op = (r < 20) ? mst_pkg::OP_ATTACH : (r < 85) ? mst_pkg::OP_TICK
                  : (r < 97) ? mst_pkg::OP_DETACH : OP_UNUSED;
          default: op = (r < 10) ? mst_pkg::OP_ATTACH : (r < 45) ? mst_pkg::OP_TICK
                        : (r < 97) ? mst_pkg::OP_DETACH : OP_UNUSED;
        endcase
        if (op == mst_pkg::OP_ATTACH) queue_req(op, 3'($urandom), pick_period(), 1'($urandom));
        else queue_req(op, 3'($urandom), 31'($urandom), 1'($urandom));
        made++;
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d transactions: %0d ticks (%0d with a slot firing)",
             n_accepted, n_tick, n_fire_ticks);
    $display("also %0d attaches (%0d on a full table), %0d detaches, %0d unused, %0d mismatches",
             n_attach, n_full, n_detach, n_unused, n_mismatch);
    if (n_mismatch == 0 && expected_rsps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mst_pkg.sv
rtl/mst_mem.sv
rtl/mst_dec.sv
rtl/multi_slot_countdown_timer_unit.sv
sim/tb_top.sv
